>>> src/rgba_3x3_kernel_filter_unit_macros.svh
// assertion macros shared by the filter unit rtl
`ifndef RGBA_3X3_KERNEL_FILTER_UNIT_MACROS_SVH
`define RGBA_3X3_KERNEL_FILTER_UNIT_MACROS_SVH
`ifndef SYNTH
`define RKF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rkf assertion failed");
`define RKF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rkf assertion failed");
`else
`define RKF_ASSERT_IMP(label, ante, cons)
`define RKF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/rkf_pkg.sv
// shared types and constants of the rgba 3x3 kernel filter
package rkf_pkg;

    localparam int PIX_W = 32;
    localparam int CH_W = 8;
    localparam int CFG_W = 12;
    localparam int IDX_W = 2;
    localparam int MODE_W = 3;
    localparam int SUM_W = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_FILTER_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_PASS = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INVERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLUR = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EDGE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EMBOSS = 3'd4;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;
    localparam logic [11:0] DIV9_MUL = 12'd3641;

    typedef struct packed {
        logic [CFG_W-1:0]  frame_width;
        logic [CFG_W-1:0]  frame_height;
        logic [MODE_W-1:0] filter_mode;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic drain;
        logic emit;
        logic sel_middle;
        logic interior;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic [2:0][SUM_W-1:0] sum;
        logic [PIX_W-1:0]      centre;
        logic                  interior;
        logic                  last;
    } qent_t;

endpackage

>>> src/rkf_ram.sv
// generic single write, single read ram with registered read data
module rkf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/rkf_front.sv
// front end: stream position, pending count, emit decisions and line store reads
`include "rgba_3x3_kernel_filter_unit_macros.svh"
module rkf_front import rkf_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         restart,
    input  logic                         take,
    input  logic                         action,
    input  logic [PIX_W-1:0]             px,
    output logic                         rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output cmd_t                         cmd,
    output logic [$clog2(MAX_WIDTH)-1:0] cmd_addr,
    output logic [PIX_W-1:0]             cmd_px
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int WEXT = (WW > CFG_W) ? WW : CFG_W;
    localparam int HEXT = (HW > CFG_W) ? HW : CFG_W;

    logic [CW-1:0] col_reg, col_next, ocol_reg, ocol_next, ocol_base;
    logic [RW-1:0] row_reg, row_next, orow_reg, orow_next, orow_base;
    logic [PW-1:0] pend_reg, pend_next, pend_base;
    cmd_t          cmd_reg, cmd_next;
    logic [CW-1:0] cmd_addr_reg;
    logic [PIX_W-1:0] cmd_px_reg;

    logic [WEXT-1:0] fw_ext;
    logic [HEXT-1:0] fh_ext;
    logic [WW-1:0]   eff_w, col_p1, ocol_p1;
    logic [HW-1:0]   eff_h, row_p1, orow_p1;
    logic            at_start, drain_ok, flush, emit_px, emit;

    assign fw_ext = WEXT'(cfg.frame_width);
    assign fh_ext = HEXT'(cfg.frame_height);

    always_comb
    begin
        if (fw_ext == '0)
        begin
            eff_w = WW'(1);
        end
        else if (fw_ext > WEXT'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(fw_ext);
        end
        if (fh_ext == '0)
        begin
            eff_h = HW'(1);
        end
        else if (fh_ext > HEXT'(MAX_HEIGHT))
        begin
            eff_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HW'(fh_ext);
        end
    end

    assign at_start = (col_reg == '0) && (row_reg == '0);
    assign drain_ok = at_start && (pend_reg != '0);
    // a pixel at frame start drops what the old frame left pending
    assign flush = !action && drain_ok;
    assign ocol_base = flush ? '0 : ocol_reg;
    assign orow_base = flush ? '0 : orow_reg;
    assign pend_base = flush ? '0 : pend_reg;

    assign col_p1 = WW'(col_reg) + WW'(1);
    assign row_p1 = HW'(row_reg) + HW'(1);
    assign ocol_p1 = WW'(ocol_base) + WW'(1);
    assign orow_p1 = HW'(orow_base) + HW'(1);

    assign emit_px = pend_base > PW'(eff_w);
    assign emit = action ? drain_ok : emit_px;

    assign rd_en = take && (!action || drain_ok);
    assign rd_addr = action ? ocol_reg : col_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        pend_next = pend_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
            pend_next = '0;
            ocol_next = '0;
            orow_next = '0;
        end
        else if (rd_en)
        begin
            ocol_next = ocol_base;
            orow_next = orow_base;
            if (!action)
            begin
                pend_next = emit_px ? pend_base : pend_base + PW'(1);
                if (col_p1 >= eff_w)
                begin
                    col_next = '0;
                    row_next = (row_p1 >= eff_h) ? '0 : RW'(row_p1);
                end
                else
                begin
                    col_next = CW'(col_p1);
                end
            end
            else
            begin
                pend_next = pend_reg - PW'(1);
            end
            if (emit)
            begin
                if (ocol_p1 >= eff_w)
                begin
                    ocol_next = '0;
                    orow_next = (orow_p1 >= eff_h) ? '0 : RW'(orow_p1);
                end
                else
                begin
                    ocol_next = CW'(ocol_p1);
                end
            end
        end
    end

    always_comb
    begin
        cmd_next.valid = rd_en;
        cmd_next.drain = action;
        cmd_next.emit = emit;
        cmd_next.sel_middle = (orow_p1 == eff_h);
        cmd_next.interior = (eff_w >= WW'(3)) && (eff_h >= HW'(3)) &&
                            (ocol_base != '0) && (ocol_p1 < eff_w) &&
                            (orow_base != '0) && (orow_p1 < eff_h);
        cmd_next.last = (ocol_p1 == eff_w) && (orow_p1 == eff_h);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            pend_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
            cmd_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            pend_reg <= pend_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            cmd_reg <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cmd_addr_reg <= col_reg;
            cmd_px_reg <= px;
        end
    end

    assign cmd = cmd_reg;
    assign cmd_addr = cmd_addr_reg;
    assign cmd_px = cmd_px_reg;

    `RKF_ASSERT_IMP(a_pending_bound, 1'b1, pend_reg <= PW'(eff_w) + PW'(1))

endmodule

>>> src/rkf_window.sv
// line stores, 3x3 window and kernel sums feeding the result queue
`include "rgba_3x3_kernel_filter_unit_macros.svh"
module rkf_window import rkf_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [MODE_W-1:0]            mode,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  cmd_t                         cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0] cmd_addr,
    input  logic [PIX_W-1:0]             cmd_px,
    output logic                         push,
    output qent_t                        push_data,
    output logic [1:0]                   inflight
);

    logic             wr_en;
    logic [PIX_W-1:0] upper_rdata, middle_rdata, up_rd, mid_rd;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_upper_reg, fwd_middle_reg;
    logic [8:0][PIX_W-1:0] window_reg;
    logic             s2_valid_reg, s2_drain_reg, s2_interior_reg, s2_last_reg;
    logic [PIX_W-1:0] s2_centre_reg, centre;

    function automatic logic signed [SUM_W-1:0] ext(input logic [CH_W-1:0] v);
        return $signed({{(SUM_W - CH_W){1'b0}}, v});
    endfunction

    function automatic logic [SUM_W-1:0] kern_sum(input logic [MODE_W-1:0] m,
                                                  input logic [8:0][CH_W-1:0] p);
        logic signed [SUM_W-1:0] box, lap, emb;
        box = ext(p[0]) + ext(p[1]) + ext(p[2]) + ext(p[3]) + ext(p[4]) +
              ext(p[5]) + ext(p[6]) + ext(p[7]) + ext(p[8]);
        lap = ext(p[1]) + ext(p[3]) + ext(p[5]) + ext(p[7]) - (ext(p[4]) <<< 2);
        emb = ext(p[4]) + ext(p[5]) + ext(p[7]) + (ext(p[8]) <<< 1) -
              (ext(p[0]) <<< 1) - ext(p[1]) - ext(p[3]);
        case (m)
            MODE_EDGE:   return lap;
            MODE_EMBOSS: return emb;
            default:     return box;
        endcase
    endfunction

    assign wr_en = cmd.valid && !cmd.drain;

    rkf_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_upper (
        .clk(clk),
        .we(wr_en),
        .waddr(cmd_addr),
        .wdata(mid_rd),
        .re(rd_en),
        .raddr(rd_addr),
        .rdata(upper_rdata)
    );

    rkf_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_middle (
        .clk(clk),
        .we(wr_en),
        .waddr(cmd_addr),
        .wdata(cmd_px),
        .re(rd_en),
        .raddr(rd_addr),
        .rdata(middle_rdata)
    );

    // bypass a read that hits the entry being written in the same cycle
    assign up_rd = fwd_reg ? fwd_upper_reg : upper_rdata;
    assign mid_rd = fwd_reg ? fwd_middle_reg : middle_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                fwd_reg <= wr_en && (cmd_addr == rd_addr);
            end
            s2_valid_reg <= cmd.valid && cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_upper_reg <= mid_rd;
            fwd_middle_reg <= cmd_px;
        end
        if (wr_en)
        begin
            window_reg[0] <= window_reg[1];
            window_reg[1] <= window_reg[2];
            window_reg[2] <= up_rd;
            window_reg[3] <= window_reg[4];
            window_reg[4] <= window_reg[5];
            window_reg[5] <= mid_rd;
            window_reg[6] <= window_reg[7];
            window_reg[7] <= window_reg[8];
            window_reg[8] <= cmd_px;
        end
        if (cmd.valid)
        begin
            s2_drain_reg <= cmd.drain;
            s2_interior_reg <= cmd.interior;
            s2_last_reg <= cmd.last;
            s2_centre_reg <= cmd.sel_middle ? mid_rd : up_rd;
        end
    end

    assign centre = s2_drain_reg ? s2_centre_reg : window_reg[4];

    always_comb
    begin
        logic [8:0][CH_W-1:0] taps;
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 9; i++)
            begin
                taps[i] = window_reg[i][CH_W*j +: CH_W];
            end
            push_data.sum[j] = kern_sum(mode, taps);
        end
        push_data.centre = centre;
        push_data.interior = s2_interior_reg;
        push_data.last = s2_last_reg;
    end

    assign push = s2_valid_reg;
    assign inflight = 2'(cmd.valid && cmd.emit) + 2'(s2_valid_reg);

    `RKF_ASSERT_NEXT(a_read_then_cmd, rd_en, cmd.valid)

endmodule

>>> src/rkf_queue.sv
// short result queue between the window stage and the output stage
`include "rgba_3x3_kernel_filter_unit_macros.svh"
module rkf_queue import rkf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  qent_t             push_data,
    input  logic              pop,
    output qent_t             pop_data,
    output logic              not_empty,
    output logic [QCNT_W-1:0] count
);

    qent_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count = count_reg;

    `RKF_ASSERT_IMP(a_no_overflow, push, count_reg < QCNT_W'(QUEUE_DEPTH))
    `RKF_ASSERT_IMP(a_no_underflow, pop, count_reg != '0)

endmodule

>>> src/rkf_back.sv
// back end: divide, clamp or invert per channel and hold the output word
module rkf_back import rkf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [MODE_W-1:0] mode,
    input  logic              q_valid,
    input  qent_t             q_data,
    output logic              pop,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [CH_W-1:0]   out_red,
    output logic [CH_W-1:0]   out_green,
    output logic [CH_W-1:0]   out_blue,
    output logic [CH_W-1:0]   out_alpha,
    output logic              frame_last
);

    logic                 out_valid_reg, load;
    logic [2:0][CH_W-1:0] ch_reg, ch_next;
    logic [CH_W-1:0]      alpha_reg;
    logic                 last_reg;

    function automatic logic [CH_W-1:0] finish_ch(input logic [MODE_W-1:0] m,
                                                  input logic interior,
                                                  input logic [SUM_W-1:0] sum,
                                                  input logic [CH_W-1:0] raw);
        logic [23:0]     prod;
        logic [8:0]      quo;
        logic [CH_W-1:0] res;
        // sum / 9 as a reciprocal multiply, exact over the blur range
        prod = 24'(sum[11:0]) * 24'(DIV9_MUL);
        quo = prod[23:15];
        res = raw;
        case (m)
            MODE_INVERT:
            begin
                res = CH_MAX - raw;
            end
            MODE_BLUR:
            begin
                if (interior)
                begin
                    res = (quo > 9'(CH_MAX)) ? CH_MAX : quo[CH_W-1:0];
                end
            end
            MODE_EDGE, MODE_EMBOSS:
            begin
                if (interior)
                begin
                    if (sum[SUM_W-1])
                    begin
                        res = '0;
                    end
                    else if (sum[SUM_W-2:CH_W] != '0)
                    begin
                        res = CH_MAX;
                    end
                    else
                    begin
                        res = sum[CH_W-1:0];
                    end
                end
            end
            default:
            begin
                res = raw;
            end
        endcase
        return res;
    endfunction

    assign load = !out_valid_reg || out_ready;
    assign pop = q_valid && load;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            ch_next[j] = finish_ch(mode, q_data.interior, q_data.sum[j],
                                   q_data.centre[CH_W*j +: CH_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ch_reg <= ch_next;
            alpha_reg <= q_data.centre[PIX_W-1 -: CH_W];
            last_reg <= q_data.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red = ch_reg[0];
    assign out_green = ch_reg[1];
    assign out_blue = ch_reg[2];
    assign out_alpha = alpha_reg;
    assign frame_last = last_reg;

endmodule

>>> src/rgba_3x3_kernel_filter_unit.sv
// top level of the rgba 3x3 kernel filter unit
// Streaming 3x3 filter for raster RGBA words, one word per clock sustained in both
// directions while out_ready stays high. The filtered word for pixel p leaves once pixel
// p + width + 1 has been taken, then passes the line store read, the window stage, the
// result queue and the output register; drain words flush the final width + 1 pixels, one
// per cycle. The two line stores are rams of MAX_WIDTH words each, read once per pixel or
// effective drain word and written once per pixel, with a bypass for same-address hits;
// they need no clearing after reset. Writing frame_width or frame_height restarts the stream.
// The user must write configuration only while the unit is idle; the unit leaves it unchecked.
module rgba_3x3_kernel_filter_unit import rkf_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             action,
    input  logic [CH_W-1:0]  in_red,
    input  logic [CH_W-1:0]  in_green,
    input  logic [CH_W-1:0]  in_blue,
    input  logic [CH_W-1:0]  in_alpha,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CH_W-1:0]  out_red,
    output logic [CH_W-1:0]  out_green,
    output logic [CH_W-1:0]  out_blue,
    output logic [CH_W-1:0]  out_alpha,
    output logic             frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);

    cfg_t              cfg_reg;
    logic              restart, take;
    logic              rd_en;
    logic [CW-1:0]     rd_addr, cmd_addr;
    cmd_t              cmd;
    logic [PIX_W-1:0]  cmd_px;
    logic              push, pop, q_valid;
    qent_t             push_data, pop_data;
    logic [QCNT_W-1:0] q_count;
    logic [1:0]        inflight;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width <= FRAME_WIDTH_RESET;
            cfg_reg.frame_height <= FRAME_HEIGHT_RESET;
            cfg_reg.filter_mode <= MODE_PASS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  cfg_reg.frame_width <= cfg_wdata;
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_wdata;
                REG_FILTER_MODE:  cfg_reg.filter_mode <= cfg_wdata[MODE_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign restart = cfg_we && ((cfg_index == REG_FRAME_WIDTH) ||
                                (cfg_index == REG_FRAME_HEIGHT));

    // room is reserved in the queue for every word still in the pipeline
    assign in_ready = (QCNT_W'(q_count) + QCNT_W'(inflight)) < QCNT_W'(QUEUE_DEPTH);
    assign take = in_valid && in_ready;

    rkf_front #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .restart(restart),
        .take(take),
        .action(action),
        .px({in_alpha, in_blue, in_green, in_red}),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .cmd(cmd),
        .cmd_addr(cmd_addr),
        .cmd_px(cmd_px)
    );

    rkf_window #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_window (
        .clk(clk),
        .rst_n(rst_n),
        .mode(cfg_reg.filter_mode),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .cmd(cmd),
        .cmd_addr(cmd_addr),
        .cmd_px(cmd_px),
        .push(push),
        .push_data(push_data),
        .inflight(inflight)
    );

    rkf_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_data(push_data),
        .pop(pop),
        .pop_data(pop_data),
        .not_empty(q_valid),
        .count(q_count)
    );

    rkf_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .mode(cfg_reg.filter_mode),
        .q_valid(q_valid),
        .q_data(pop_data),
        .pop(pop),
        .out_ready(out_ready),
        .out_valid(out_valid),
        .out_red(out_red),
        .out_green(out_green),
        .out_blue(out_blue),
        .out_alpha(out_alpha),
        .frame_last(frame_last)
    );

endmodule

>>> dv/rkf_pixel_checker.sv
// predicts and checks the filtered pixel words of the rgba 3x3 kernel filter unit
`timescale 1ns / 100ps

module rkf_pixel_checker import rkf_pkg::*; #(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 2048
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             action,
    input  logic [CH_W-1:0]  in_red,
    input  logic [CH_W-1:0]  in_green,
    input  logic [CH_W-1:0]  in_blue,
    input  logic [CH_W-1:0]  in_alpha,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [CH_W-1:0]  out_red,
    input  logic [CH_W-1:0]  out_green,
    input  logic [CH_W-1:0]  out_blue,
    input  logic [CH_W-1:0]  out_alpha,
    input  logic             frame_last,
    output int               mismatch_count,
    output int               outstanding
);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            last;
    } rgba_word_t;

    rgba_word_t filtered_q[$];

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [PIX_W-1:0]  upper_line [MAX_COLS];
    logic [PIX_W-1:0]  middle_line [MAX_COLS];
    logic [PIX_W-1:0]  window [9];
    int                in_col;
    int                in_row;
    int                backlog;
    int                emit_col;
    int                emit_row;

    function automatic int eff_cols();
        if (width_reg == '0)
            return 1;
        if (int'(width_reg) > MAX_COLS)
            return MAX_COLS;
        return int'(width_reg);
    endfunction

    function automatic int eff_rows();
        if (height_reg == '0)
            return 1;
        if (int'(height_reg) > MAX_ROWS)
            return MAX_ROWS;
        return int'(height_reg);
    endfunction

    function automatic void rewind_stream();
        in_col = 0;
        in_row = 0;
        backlog = 0;
        emit_col = 0;
        emit_row = 0;
        for (int i = 0; i < 9; i++)
            window[i] = '0;
    endfunction

    function automatic int kernel_result(input int sh);
        int p [9];
        int acc;
        for (int i = 0; i < 9; i++)
            p[i] = int'(window[i][sh +: CH_W]);
        case (mode_reg)
            MODE_BLUR:
                acc = (p[0] + p[1] + p[2] + p[3] + p[4] + p[5] + p[6] + p[7] + p[8]) / 9;
            MODE_EDGE:
                acc = p[1] + p[3] + p[5] + p[7] - 4 * p[4];
            default:
                acc = -2 * p[0] - p[1] - p[3] + p[4] + p[5] + p[7] + 2 * p[8];
        endcase
        if (acc < 0)
            acc = 0;
        if (acc > int'(CH_MAX))
            acc = int'(CH_MAX);
        return acc;
    endfunction

    // filters the centre pixel at the emit position and steps that position
    function automatic rgba_word_t filter_centre(input logic [PIX_W-1:0] centre,
                                                 input int w, input int h);
        rgba_word_t     res;
        bit             inner;
        logic [CH_W-1:0] ch [3];
        inner = w >= 3 && h >= 3 && emit_col >= 1 && emit_col + 2 <= w &&
                emit_row >= 1 && emit_row + 2 <= h;
        for (int j = 0; j < 3; j++)
        begin
            ch[j] = centre[CH_W*j +: CH_W];
            if (mode_reg == MODE_INVERT)
                ch[j] = CH_MAX - ch[j];
            else if (inner && (mode_reg == MODE_BLUR || mode_reg == MODE_EDGE ||
                               mode_reg == MODE_EMBOSS))
                ch[j] = CH_W'(kernel_result(CH_W * j));
        end
        res.red = ch[0];
        res.green = ch[1];
        res.blue = ch[2];
        res.alpha = centre[PIX_W-1 -: CH_W];
        res.last = (emit_col + 1 == w) && (emit_row + 1 == h);
        emit_col++;
        if (emit_col >= w)
        begin
            emit_col = 0;
            emit_row++;
            if (emit_row >= h)
                emit_row = 0;
        end
        return res;
    endfunction

    task automatic take_word();
        int              w;
        int              h;
        int              c;
        int              x;
        bit              at_start;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] wrap_centre;
        w = eff_cols();
        h = eff_rows();
        at_start = (in_col == 0) && (in_row == 0);
        if (action)
        begin
            // drain tick: only once the frame is complete
            if (at_start && backlog != 0)
            begin
                x = (emit_col < w) ? emit_col : 0;
                filtered_q.push_back(filter_centre((emit_row + 1 == h) ? middle_line[x]
                                                                        : upper_line[x], w, h));
                backlog--;
            end
        end
        else
        begin
            px = {in_alpha, in_blue, in_green, in_red};
            c = (in_col < w) ? in_col : 0;
            wrap_centre = upper_line[w-1];
            // new frame drops whatever the old one left pending
            if (at_start && backlog != 0)
            begin
                backlog = 0;
                emit_col = 0;
                emit_row = 0;
            end
            for (int r = 0; r < 3; r++)
            begin
                window[3*r] = window[3*r+1];
                window[3*r+1] = window[3*r+2];
            end
            window[2] = upper_line[c];
            window[5] = middle_line[c];
            window[8] = px;
            upper_line[c] = middle_line[c];
            middle_line[c] = px;
            in_col = c + 1;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= h)
                    in_row = 0;
            end
            backlog++;
            if (backlog > w + 1)
            begin
                filtered_q.push_back(filter_centre((c >= 1) ? window[4] : wrap_centre, w, h));
                backlog--;
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [CH_W-1:0] want,
                                 input logic [CH_W-1:0] got);
        if (want !== got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_word();
        rgba_word_t want;
        if (filtered_q.size() == 0)
        begin
            $error("unexpected output word red %0d green %0d blue %0d alpha %0d last %0d",
                   out_red, out_green, out_blue, out_alpha, frame_last);
            mismatch_count++;
        end
        else
        begin
            want = filtered_q.pop_front();
            compare_field("out_red", want.red, out_red);
            compare_field("out_green", want.green, out_green);
            compare_field("out_blue", want.blue, out_blue);
            compare_field("out_alpha", want.alpha, out_alpha);
            compare_field("frame_last", CH_W'(want.last), CH_W'(frame_last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            mode_reg = MODE_PASS;
            for (int i = 0; i < MAX_COLS; i++)
            begin
                upper_line[i] = '0;
                middle_line[i] = '0;
            end
            rewind_stream();
            filtered_q.delete();
            mismatch_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:
                    begin
                        width_reg = cfg_wdata;
                        rewind_stream();
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        height_reg = cfg_wdata;
                        rewind_stream();
                    end
                    REG_FILTER_MODE:
                        mode_reg = cfg_wdata[MODE_W-1:0];
                    default:
                        ;
                endcase
            end
            if (in_valid && in_ready)
                take_word();
            if (out_valid && out_ready)
                check_word();
            outstanding = filtered_q.size();
        end
    end

endmodule

>>> dv/tb.sv
// testbench top: stimulus, flow control and verdict for the rgba 3x3 kernel filter unit
`timescale 1ns / 100ps

module tb;
    import rkf_pkg::*;

    localparam logic             ACT_PIXEL = 1'b0;
    localparam logic             ACT_DRAIN = 1'b1;
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int               RANDOM_ITEMS = 1100;
    localparam int               HOLD_CYCLES = 400;
    localparam int               SETTLE_CYCLES = 8;
    localparam int               CYCLE_LIMIT = 400000;
    localparam int               WIDE_PIXELS = 64;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_ready;
    logic             action;
    logic [CH_W-1:0]  in_red;
    logic [CH_W-1:0]  in_green;
    logic [CH_W-1:0]  in_blue;
    logic [CH_W-1:0]  in_alpha;
    logic             out_valid;
    logic             out_ready;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic [CH_W-1:0]  out_alpha;
    logic             frame_last;

    int mismatch_count;
    int outstanding;
    int burst_left;
    int cycle_count;
    bit hold_req;

    rgba_3x3_kernel_filter_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .in_alpha   (in_alpha),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .frame_last (frame_last)
    );

    rkf_pixel_checker pixel_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .in_red         (in_red),
        .in_green       (in_green),
        .in_blue        (in_blue),
        .in_alpha       (in_alpha),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_red        (out_red),
        .out_green      (out_green),
        .out_blue       (out_blue),
        .out_alpha      (out_alpha),
        .frame_last     (frame_last),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [CH_W-1:0] rand_channel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CH_MAX;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    // one word per call; valid stays up across a burst
    task automatic send_word(input logic act, input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                             input logic [CH_W-1:0] b, input logic [CH_W-1:0] a);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        action <= act;
        in_red <= r;
        in_green <= g;
        in_blue <= b;
        in_alpha <= a;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random_pixel();
        send_word(ACT_PIXEL, rand_channel(), rand_channel(), rand_channel(), rand_channel());
    endtask

    task automatic send_drain();
        send_word(ACT_DRAIN, rand_channel(), rand_channel(), rand_channel(), rand_channel());
    endtask

    // wait until every filtered word is out and the pipeline is quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // one frame, or a cut-off piece of one; returns the words that count
    task automatic send_frame(input int cols, input int rows, input bit partial,
                              output int counted);
        int total;
        int n;
        int queued;
        int drains;
        total = cols * rows;
        n = partial ? $urandom_range(1, total) : total;
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(0, 15) == 0)
                send_drain();
            send_random_pixel();
        end
        counted = n;
        if (!partial)
        begin
            queued = (total < cols + 1) ? total : cols + 1;
            case ($urandom_range(0, 9))
                0: drains = $urandom_range(0, queued - 1);
                1: drains = queued + $urandom_range(1, 3);
                default: drains = queued;
            endcase
            repeat (drains) send_drain();
            counted += (drains < queued) ? drains : queued;
        end
    endtask

    // receiver: stall patterns plus one long hold-off on request
    initial
    begin : receiver
        int  seg_left;
        int  style;
        bit  held;
        out_ready = 1'b0;
        seg_left = 0;
        style = 0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    style = $urandom_range(0, 3);
                    seg_left = $urandom_range(32, 200);
                end
                seg_left--;
                case (style)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ((seg_left / 8) % 2 == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int               w_val;
        int               h_val;
        int               frames;
        int               counted;
        int               random_items;
        logic [MODE_W-1:0] mode_val;
        bit               need_restart;
        bit               hold_now;
        bit               partial;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        action = ACT_PIXEL;
        in_red = '0;
        in_green = '0;
        in_blue = '0;
        in_alpha = '0;
        hold_req = 1'b0;
        burst_left = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // drain with nothing pending, unknown register, zero sizes
        send_drain();
        settle();
        write_reg(REG_UNUSED, '1);
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, '0);
        write_reg(REG_FILTER_MODE, MODE_INVERT);
        end_writes();
        send_word(ACT_PIXEL, '0, '0, '0, '0);
        send_drain();
        send_word(ACT_PIXEL, CH_MAX, CH_MAX, CH_MAX, CH_MAX);
        send_random_pixel();
        send_drain();
        send_drain();

        // 3x3 edge frame saturating both ways, early drain ignored
        settle();
        write_reg(REG_FRAME_WIDTH, 12'd3);
        write_reg(REG_FRAME_HEIGHT, 12'd3);
        write_reg(REG_FILTER_MODE, MODE_EDGE);
        end_writes();
        for (int i = 0; i < 9; i++)
        begin
            if (i == 5)
                send_drain();
            send_word(ACT_PIXEL, (i == 4) ? '0 : CH_MAX, (i == 4) ? CH_MAX : '0,
                      rand_channel(), rand_channel());
        end
        repeat (5) send_drain();

        // oversized sizes: a short piece of a row at the saturated width
        settle();
        write_reg(REG_FRAME_WIDTH, '1);
        write_reg(REG_FRAME_HEIGHT, '1);
        write_reg(REG_FILTER_MODE, MODE_BLUR);
        end_writes();
        for (int i = 0; i < WIDE_PIXELS; i++)
        begin
            if (i == WIDE_PIXELS / 2)
                send_drain();
            send_random_pixel();
        end

        random_items = 0;
        need_restart = 1'b1;
        w_val = 1;
        h_val = 1;
        while (random_items < RANDOM_ITEMS)
        begin
            hold_now = !hold_req && random_items >= 400;
            settle();
            if (hold_now)
            begin
                w_val = 12;
                h_val = 5;
                mode_val = MODE_EMBOSS;
                need_restart = 1'b1;
            end
            else
            begin
                mode_val = ($urandom_range(0, 3) == 0) ? MODE_W'($urandom_range(0, 7))
                                                      : MODE_W'($urandom_range(MODE_BLUR,
                                                                               MODE_EMBOSS));
                if (need_restart || $urandom_range(0, 4) != 0)
                begin
                    need_restart = 1'b1;
                    case ($urandom_range(0, 19))
                        0: w_val = 0;
                        1: w_val = $urandom_range(9, 40);
                        default: w_val = $urandom_range(1, 8);
                    endcase
                    h_val = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (need_restart)
            begin
                write_reg(REG_FRAME_WIDTH, CFG_W'(w_val));
                write_reg(REG_FRAME_HEIGHT, CFG_W'(h_val));
            end
            write_reg(REG_FILTER_MODE, CFG_W'(mode_val));
            end_writes();
            if (hold_now)
                hold_req = 1'b1;
            need_restart = 1'b0;
            frames = hold_now ? 2 : $urandom_range(1, 4);
            for (int f = 0; f < frames; f++)
            begin
                partial = !hold_now && $urandom_range(0, 9) == 0;
                send_frame((w_val == 0) ? 1 : w_val, (h_val == 0) ? 1 : h_val, partial, counted);
                random_items += counted;
                if (partial)
                begin
                    need_restart = 1'b1;
                    break;
                end
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
